>>> design/dpp_pkg.sv
// Package for the decimal price parser: widths, character codes, parse phases
// and the records passed between the scan and scale stages. No dependencies.
`default_nettype none

package dpp_pkg;

  localparam int BYTE_W          = 8;
  localparam int WHOLE_W         = 19;
  localparam int FRAC_W          = 14;
  localparam int COUNT_W         = 3;
  localparam int PRICE_W         = 32;
  localparam int PROD_W          = WHOLE_W + FRAC_W;
  localparam int FRACTION_DIGITS = 4;

  localparam logic [WHOLE_W-1:0] WHOLE_MAX       = 19'd524287;
  localparam logic [WHOLE_W-1:0] MAX_WHOLE_RESET = 19'd199999;
  localparam logic [FRAC_W-1:0]  UNITS_PER_WHOLE = 14'd10000;

  localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'd9;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'd43;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'd45;
  localparam logic [BYTE_W-1:0] CH_POINT = 8'd46;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'd48;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'd57;

  typedef enum logic [5:0] {
    PH_FIRST = 6'b000001,
    PH_SPACE = 6'b000010,
    PH_SIGN  = 6'b000100,
    PH_WHOLE = 6'b001000,
    PH_FRAC  = 6'b010000,
    PH_DONE  = 6'b100000
  } phase_t;

  // Parse state at the end of one price text.
  typedef struct packed {
    logic [WHOLE_W-1:0] whole;
    logic               overflow;
    logic               minus;
    logic [FRAC_W-1:0]  frac;
  } summary_t;

  // Weight of a fraction digit by its position after the point.
  function automatic logic [FRAC_W-1:0] frac_weight(input logic [1:0] pos);
    logic [FRAC_W-1:0] w;
    case (pos)
      2'd0:    w = 14'd1000;
      2'd1:    w = 14'd100;
      2'd2:    w = 14'd10;
      default: w = 14'd1;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> design/dpp_if.sv
// Valid/ready channel interfaces for the decimal price parser.
// Depends on dpp_pkg for field widths.
`default_nettype none

interface dpp_in_if;
  logic                       valid;
  logic                       ready;
  logic [dpp_pkg::BYTE_W-1:0] text_byte;
  logic                       last_byte;

  modport source (output valid, output text_byte, output last_byte, input ready);
  modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

interface dpp_out_if;
  logic                        valid;
  logic                        ready;
  logic [dpp_pkg::PRICE_W-1:0] price_units;
  logic                        parse_ok;

  modport source (output valid, output price_units, output parse_ok, input ready);
  modport sink   (input valid, input price_units, input parse_ok, output ready);
endinterface

`default_nettype wire

>>> design/decimal_price_parser.sv
// Decimal price parser top level: configuration register, scanner and scaler.
// Depends on dpp_pkg, dpp_if, dpp_scan and dpp_scale.
//
// Usage: price text enters on in_ch one byte per request (text_byte), with
// last_byte set on the final byte of a price. Each final byte yields one
// request on out_ch: price_units in ten-thousandths and parse_ok; a failed
// parse gives price_units of zero. Bytes without last_byte yield nothing.
// cfg_wr_en writes cfg_wr_data into max_whole, the largest accepted whole part;
// write it only while no price is in flight.
// Throughput: one byte per cycle unless a final byte waits for room, set by the
// parse state update that each byte makes in the scanner.
// Path of a final byte: the input register, the scan state update into the summary
// register, the multiply by 10000, then the fraction add and clamp into the
// result register.
// Reset: synchronous, rst_n low; parse state clears, max_whole returns to
// 199999, and no request is pending. There is no clearing pass.
// Stall: while out_ch.ready is low the result holds; the pipeline takes bytes
// until its three holding registers fill; a final byte then drops in_ch.ready.
`default_nettype none

module decimal_price_parser (
  input  logic                        clk,
  input  logic                        rst_n,
  dpp_in_if.sink                      in_ch,
  dpp_out_if.source                   out_ch,
  input  logic                        cfg_wr_en,
  input  logic [dpp_pkg::WHOLE_W-1:0] cfg_wr_data
);

  logic [dpp_pkg::WHOLE_W-1:0] max_whole_r;
  dpp_pkg::summary_t           sum_data;
  logic                        sum_valid;
  logic                        sum_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_whole_r <= dpp_pkg::MAX_WHOLE_RESET;
    end else if (cfg_wr_en) begin
      max_whole_r <= cfg_wr_data;
    end
  end

  dpp_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .sum_data  (sum_data),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready)
  );

  dpp_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .max_whole (max_whole_r),
    .sum_data  (sum_data),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

>>> design/dpp_scan.sv
// Byte scanner: input register plus the per-byte parse state update.
// Emits one summary record per price text. Depends on dpp_pkg and dpp_if.
`default_nettype none

module dpp_scan (
  input  logic              clk,
  input  logic              rst_n,
  dpp_in_if.sink            in_ch,
  output dpp_pkg::summary_t sum_data,
  output logic              sum_valid,
  input  logic              sum_ready
);

  logic                          a_valid_r;
  logic [dpp_pkg::BYTE_W-1:0]    a_byte_r;
  logic                          a_last_r;

  dpp_pkg::phase_t               phase_r, phase_nxt;
  logic [dpp_pkg::WHOLE_W-1:0]   whole_r, whole_nxt;
  logic                          ovf_r, ovf_nxt;
  logic                          minus_r, minus_nxt;
  logic [dpp_pkg::FRAC_W-1:0]    frac_r, frac_nxt;
  logic [dpp_pkg::COUNT_W-1:0]   cnt_r, cnt_nxt;

  logic                          b_valid_r;
  dpp_pkg::summary_t             b_data_r;

  logic                          a_adv;
  logic                          b_take;
  logic                          is_space, is_digit;
  logic [3:0]                    digit;
  logic [dpp_pkg::WHOLE_W+3:0]   whole_ext;
  logic [dpp_pkg::WHOLE_W+3:0]   whole_sum;
  logic [dpp_pkg::WHOLE_W-1:0]   whole_add;
  logic                          ovf_add;
  logic [dpp_pkg::FRAC_W-1:0]    frac_add;

  // A final byte needs room in the summary register; other bytes always move.
  assign b_take      = b_valid_r && sum_ready;
  assign a_adv       = a_valid_r && (!a_last_r || !b_valid_r || sum_ready);
  assign in_ch.ready = !a_valid_r || a_adv;

  assign sum_valid = b_valid_r;
  assign sum_data  = b_data_r;

  always_comb begin
    is_space = (a_byte_r == dpp_pkg::CH_SPACE) ||
               (a_byte_r inside {[dpp_pkg::CH_TAB:dpp_pkg::CH_CR]});
    is_digit = a_byte_r inside {[dpp_pkg::CH_ZERO:dpp_pkg::CH_NINE]};
    digit    = a_byte_r[3:0];

    // Whole part times ten plus the digit, saturating once it leaves 19 bits.
    whole_ext = {4'd0, whole_r};
    whole_sum = (whole_ext << 3) + (whole_ext << 1) + {19'd0, digit};
    if (ovf_r || whole_sum > {4'd0, dpp_pkg::WHOLE_MAX}) begin
      whole_add = dpp_pkg::WHOLE_MAX;
      ovf_add   = 1'b1;
    end else begin
      whole_add = whole_sum[dpp_pkg::WHOLE_W-1:0];
      ovf_add   = 1'b0;
    end

    frac_add = frac_r +
               dpp_pkg::FRAC_W'({10'd0, digit} * dpp_pkg::frac_weight(cnt_r[1:0]));
  end

  always_comb begin
    phase_nxt = phase_r;
    whole_nxt = whole_r;
    ovf_nxt   = ovf_r;
    minus_nxt = minus_r;
    frac_nxt  = frac_r;
    cnt_nxt   = cnt_r;
    case (phase_r)
      dpp_pkg::PH_FIRST, dpp_pkg::PH_SPACE: begin
        if (is_space) begin
          phase_nxt = dpp_pkg::PH_SPACE;
        end else if (a_byte_r == dpp_pkg::CH_PLUS || a_byte_r == dpp_pkg::CH_MINUS) begin
          minus_nxt = (a_byte_r == dpp_pkg::CH_MINUS);
          phase_nxt = dpp_pkg::PH_SIGN;
        end else if (is_digit) begin
          whole_nxt = whole_add;
          ovf_nxt   = ovf_add;
          phase_nxt = dpp_pkg::PH_WHOLE;
        end else if (a_byte_r == dpp_pkg::CH_POINT && phase_r == dpp_pkg::PH_FIRST) begin
          // A point counts without whole digits only as the very first byte.
          phase_nxt = dpp_pkg::PH_FRAC;
        end else begin
          phase_nxt = dpp_pkg::PH_DONE;
        end
      end
      dpp_pkg::PH_SIGN: begin
        if (is_digit) begin
          whole_nxt = whole_add;
          ovf_nxt   = ovf_add;
          phase_nxt = dpp_pkg::PH_WHOLE;
        end else begin
          phase_nxt = dpp_pkg::PH_DONE;
        end
      end
      dpp_pkg::PH_WHOLE: begin
        if (is_digit) begin
          whole_nxt = whole_add;
          ovf_nxt   = ovf_add;
        end else if (a_byte_r == dpp_pkg::CH_POINT) begin
          phase_nxt = dpp_pkg::PH_FRAC;
        end else begin
          phase_nxt = dpp_pkg::PH_DONE;
        end
      end
      dpp_pkg::PH_FRAC: begin
        if (is_digit && cnt_r < dpp_pkg::COUNT_W'(dpp_pkg::FRACTION_DIGITS)) begin
          frac_nxt = frac_add;
          cnt_nxt  = cnt_r + 3'd1;
        end else begin
          phase_nxt = dpp_pkg::PH_DONE;
        end
      end
      default: begin
        phase_nxt = dpp_pkg::PH_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      a_valid_r <= in_ch.valid;
    end
    if (in_ch.ready) begin
      a_byte_r <= in_ch.text_byte;
      a_last_r <= in_ch.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= dpp_pkg::PH_FIRST;
      whole_r <= '0;
      ovf_r   <= 1'b0;
      minus_r <= 1'b0;
      frac_r  <= '0;
      cnt_r   <= '0;
    end else if (a_adv) begin
      if (a_last_r) begin
        phase_r <= dpp_pkg::PH_FIRST;
        whole_r <= '0;
        ovf_r   <= 1'b0;
        minus_r <= 1'b0;
        frac_r  <= '0;
        cnt_r   <= '0;
      end else begin
        phase_r <= phase_nxt;
        whole_r <= whole_nxt;
        ovf_r   <= ovf_nxt;
        minus_r <= minus_nxt;
        frac_r  <= frac_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (a_adv && a_last_r) begin
      b_valid_r <= 1'b1;
    end else if (b_take) begin
      b_valid_r <= 1'b0;
    end
    if (a_adv && a_last_r) begin
      b_data_r.whole    <= whole_nxt;
      b_data_r.overflow <= ovf_nxt;
      b_data_r.minus    <= minus_nxt;
      b_data_r.frac     <= frac_nxt;
    end
  end

  a_ovf_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> whole_r == dpp_pkg::WHOLE_MAX)
    else $error("whole overflow flag set without a saturated accumulator");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (a_adv && a_last_r) |=> (phase_r == dpp_pkg::PH_FIRST && cnt_r == '0 && !b_data_r.overflow == !$past(ovf_nxt)))
    else $error("parse state not cleared after a final byte");

  a_frac_count: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= dpp_pkg::COUNT_W'(dpp_pkg::FRACTION_DIGITS))
    else $error("fraction digit count past its limit");

endmodule

`default_nettype wire

>>> design/dpp_scale.sv
// Scaling stages: limit and sign check with the whole part times 10000, then
// the fraction add, clamp and result register. Depends on dpp_pkg and dpp_if.
`default_nettype none

module dpp_scale (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [dpp_pkg::WHOLE_W-1:0] max_whole,
  input  dpp_pkg::summary_t           sum_data,
  input  logic                        sum_valid,
  output logic                        sum_ready,
  dpp_out_if.source                   out_ch
);

  logic                         c_valid_r;
  logic [dpp_pkg::PROD_W-1:0]   c_prod_r;
  logic [dpp_pkg::FRAC_W-1:0]   c_frac_r;
  logic                         c_ok_r;

  logic                         d_valid_r;
  logic [dpp_pkg::PRICE_W-1:0]  d_price_r, d_price_nxt;
  logic                         d_ok_r;

  logic                         c_take;
  logic                         ok_nxt;
  logic [dpp_pkg::PROD_W:0]     total;

  assign c_take    = c_valid_r && (!d_valid_r || out_ch.ready);
  assign sum_ready = !c_valid_r || c_take;

  assign out_ch.valid       = d_valid_r;
  assign out_ch.price_units = d_price_r;
  assign out_ch.parse_ok    = d_ok_r;

  // A minus sign is acceptable only in front of a zero whole part.
  assign ok_nxt = !sum_data.overflow && (sum_data.whole <= max_whole) &&
                  !(sum_data.minus && sum_data.whole != '0);

  always_comb begin
    total = {1'b0, c_prod_r} + (dpp_pkg::PROD_W+1)'(c_frac_r);
    if (!c_ok_r) begin
      d_price_nxt = '0;
    end else if (total[dpp_pkg::PROD_W:dpp_pkg::PRICE_W] != '0) begin
      d_price_nxt = '1;
    end else begin
      d_price_nxt = total[dpp_pkg::PRICE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (sum_ready) begin
      c_valid_r <= sum_valid;
    end
    if (sum_ready) begin
      c_prod_r <= dpp_pkg::PROD_W'(sum_data.whole) * dpp_pkg::PROD_W'(dpp_pkg::UNITS_PER_WHOLE);
      c_frac_r <= sum_data.frac;
      c_ok_r   <= ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else if (!d_valid_r || out_ch.ready) begin
      d_valid_r <= c_valid_r;
    end
    if (c_take) begin
      d_price_r <= d_price_nxt;
      d_ok_r    <= c_ok_r;
    end
  end

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (d_valid_r && !d_ok_r) |-> d_price_r == '0)
    else $error("failed parse carries a nonzero price");

  a_result_moves: assert property (@(posedge clk) disable iff (!rst_n)
    c_take |=> (d_valid_r && d_ok_r == $past(c_ok_r)))
    else $error("scaled request lost on its way to the result register");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (d_valid_r && !out_ch.ready) |=> (d_valid_r && $stable(d_price_r) && $stable(d_ok_r)))
    else $error("result request changed while the receiver stalled");

endmodule

`default_nettype wire

>>> sim/dpp_price_checker.sv
// Scoreboard for the decimal price parser: follows the byte stream on the request
// channel, predicts each price, and compares it with the result channel.
// Depends on dpp_pkg and the channel interfaces in dpp_if.
`default_nettype none

module dpp_price_checker
  import dpp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [WHOLE_W-1:0] cfg_wr_data,
  dpp_in_if                  in_ch,
  dpp_out_if                 out_ch,
  output int                 mismatch_count,
  output int                 quotes_pending
);

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic               ok;
  } quote_t;

  localparam logic [FRAC_W-1:0] PLACE_VALUE [4] = '{14'd1000, 14'd100, 14'd10, 14'd1};

  quote_t             expected_quotes [$];
  phase_t             phase;
  logic [WHOLE_W-1:0] whole;
  logic               whole_ovf;
  logic               minus;
  logic [FRAC_W-1:0]  frac;
  logic [COUNT_W-1:0] frac_digits;
  logic [WHOLE_W-1:0] whole_limit;

  function automatic logic is_blank(input logic [BYTE_W-1:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_digit(input logic [BYTE_W-1:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  task automatic clear_parse();
    phase       = PH_FIRST;
    whole       = '0;
    whole_ovf   = 1'b0;
    minus       = 1'b0;
    frac        = '0;
    frac_digits = '0;
  endtask

  // The whole part saturates instead of wrapping; once saturated it stays there.
  task automatic add_whole_digit(input logic [3:0] d);
    logic [23:0] next_whole;
    next_whole = {5'd0, whole} * 24'd10 + {20'd0, d};
    if (whole_ovf || next_whole > {5'd0, WHOLE_MAX}) begin
      whole     = WHOLE_MAX;
      whole_ovf = 1'b1;
    end else begin
      whole = next_whole[WHOLE_W-1:0];
    end
  endtask

  task automatic predict_byte(input logic [BYTE_W-1:0] c, input logic fin);
    quote_t      q;
    logic [47:0] units;
    logic [47:0] whole_wide;
    // ASCII digits carry their value in the low nibble.
    case (phase)
      PH_FIRST, PH_SPACE: begin
        if (is_blank(c)) begin
          phase = PH_SPACE;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          minus = (c == CH_MINUS);
          phase = PH_SIGN;
        end else if (is_digit(c)) begin
          add_whole_digit(c[3:0]);
          phase = PH_WHOLE;
        end else if (c == CH_POINT && phase == PH_FIRST) begin
          phase = PH_FRAC;
        end else begin
          phase = PH_DONE;
        end
      end
      PH_SIGN: begin
        if (is_digit(c)) begin
          add_whole_digit(c[3:0]);
          phase = PH_WHOLE;
        end else begin
          phase = PH_DONE;
        end
      end
      PH_WHOLE: begin
        if (is_digit(c)) add_whole_digit(c[3:0]);
        else if (c == CH_POINT) phase = PH_FRAC;
        else phase = PH_DONE;
      end
      PH_FRAC: begin
        if (is_digit(c) && frac_digits < FRACTION_DIGITS) begin
          frac        = frac + {10'd0, c[3:0]} * PLACE_VALUE[frac_digits[1:0]];
          frac_digits = frac_digits + 3'd1;
        end else begin
          phase = PH_DONE;
        end
      end
      default: phase = PH_DONE;
    endcase

    if (fin) begin
      q.ok       = !whole_ovf && whole <= whole_limit && !(minus && whole != '0);
      whole_wide = {29'd0, whole};
      units      = q.ok ? whole_wide * 48'd10000 + {34'd0, frac} : 48'd0;
      q.price    = (units > 48'hFFFF_FFFF) ? '1 : units[PRICE_W-1:0];
      expected_quotes.push_back(q);
      clear_parse();
    end
  endtask

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    quote_t want;
    if (!rst_n) begin
      clear_parse();
      whole_limit = MAX_WHOLE_RESET;
      expected_quotes.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_wr_en) whole_limit = cfg_wr_data;
      if (in_ch.valid && in_ch.ready) predict_byte(in_ch.text_byte, in_ch.last_byte);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_quotes.size() == 0) begin
          note_mismatch($sformatf("unexpected price %0d ok=%0b",
                                  out_ch.price_units, out_ch.parse_ok));
        end else begin
          want = expected_quotes.pop_front();
          if (out_ch.price_units !== want.price || out_ch.parse_ok !== want.ok)
            note_mismatch($sformatf("expected price %0d ok=%0b, got price %0d ok=%0b",
                                    want.price, want.ok,
                                    out_ch.price_units, out_ch.parse_ok));
        end
      end
    end
    quotes_pending <= expected_quotes.size();
  end

endmodule

`default_nettype wire

>>> sim/tb.sv
// Top of the decimal price parser testbench: clock, reset, price text stimulus,
// max_whole writes and flow control on both channels; the verdict comes from the
// checker's mismatch and pending counts. Depends on dpp_pkg, dpp_if and the RTL.
`default_nettype none

module tb;
  import dpp_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [WHOLE_W-1:0] cfg_wr_data;
  int                 mismatches;
  int                 pending;
  int                 src_gap_pct;
  int                 dst_gap_pct;
  int                 hold_cycles;
  int                 bytes_sent;
  logic [WHOLE_W-1:0] whole_limit;
  logic [BYTE_W-1:0]  text_q [$];

  dpp_in_if  in_ch ();
  dpp_out_if out_ch ();

  decimal_price_parser dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  dpp_price_checker quote_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .mismatch_count (mismatches),
    .quotes_pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("decimal_price_parser test failed");
    $finish;
  end

  // Result side; a long hold-off is counted down here while the sender keeps going.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= dst_gap_pct);
      end
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fin);
    while ($urandom_range(99) < src_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.text_byte <= b;
    in_ch.last_byte <= fin;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  task automatic push_str(input string s);
    for (int k = 0; k < s.len(); k++) text_q.push_back(s[k]);
  endtask

  task automatic send_str(input string s);
    push_str(s);
    send_text();
  endtask

  // Waits out every outstanding price plus the pipeline depth.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_max_whole(input logic [WHOLE_W-1:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    whole_limit = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_random_phase(input int src_pct, input int dst_pct,
                                  input logic [WHOLE_W-1:0] limit, input int target,
                                  input int hold);
    int          start;
    int          sel;
    int          sign_sel;
    int          whole_val;
    logic [31:0] raw;
    set_max_whole(limit);
    src_gap_pct = src_pct;
    dst_gap_pct = dst_pct;
    hold_cycles = hold;
    start       = bytes_sent;
    while (bytes_sent - start < target) begin
      sel = $urandom_range(99);
      if (sel < 15) begin
        // Noise: arbitrary bytes, any of which may stop the parse early.
        repeat ($urandom_range(1, 6)) text_q.push_back(BYTE_W'($urandom_range(255)));
      end else begin
        if ($urandom_range(3) == 0) begin
          repeat ($urandom_range(1, 2)) begin
            raw = $urandom_range(8, 13);
            text_q.push_back(raw == 8 ? CH_SPACE : raw[BYTE_W-1:0]);
          end
        end
        sign_sel = $urandom_range(9);
        if (sign_sel == 0) text_q.push_back(CH_MINUS);
        else if (sign_sel <= 2) text_q.push_back(CH_PLUS);
        case ($urandom_range(5))
          0: whole_val = -1;
          1: whole_val = int'(whole_limit) - 1 + $urandom_range(2);
          2: whole_val = -2;
          default: whole_val = $urandom_range(0, whole_limit);
        endcase
        if (sign_sel == 0 && $urandom_range(1) == 0) whole_val = 0;
        if (whole_val == -2) begin
          raw = $urandom;
          push_str($sformatf("%0d", raw));
        end else if (whole_val >= 0) begin
          if ($urandom_range(7) == 0) push_str("0");
          push_str($sformatf("%0d", whole_val));
        end
        if ($urandom_range(3) != 0) begin
          text_q.push_back(CH_POINT);
          repeat ($urandom_range(0, 5))
            text_q.push_back(CH_ZERO + BYTE_W'($urandom_range(9)));
        end
        if ($urandom_range(4) == 0) text_q.push_back(BYTE_W'($urandom_range(255)));
      end
      send_text();
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    in_ch.valid     = 1'b0;
    in_ch.text_byte = '0;
    in_ch.last_byte = 1'b0;
    src_gap_pct     = 0;
    dst_gap_pct     = 0;
    hold_cycles     = 0;
    bytes_sent      = 0;
    whole_limit     = MAX_WHOLE_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed prices with the limit at its reset value.
    send_str("0");
    send_str("199999.9999");
    send_str("200000");
    push_str(" ");
    for (int c = 9; c <= 13; c++) text_q.push_back(BYTE_W'(c));
    send_str("+12.5");
    send_str("-0.5");
    send_str("-3");
    send_str(".5");
    send_str(" .5");
    send_str("+.5");
    send_str("1.23456");
    send_str("12x34");
    push_str("7");
    text_q.push_back(8'd0);
    send_str("9");
    send_str("99999999");
    text_q.push_back(8'd0);
    send_text();
    text_q.push_back(8'hFF);
    send_str("5");
    send_str("--5");
    send_str("1.");
    send_str("00012.0001");

    // Limit extremes, including one above the 32-bit price range.
    set_max_whole('0);
    send_str("0.9999");
    send_str("1");
    set_max_whole(19'd429495);
    send_str("429495.9999");
    send_str("429496");
    set_max_whole(WHOLE_MAX);
    send_str("524287.9999");
    send_str("524288");

    run_random_phase(13, 73, WHOLE_W'($urandom_range(0, 429495)), 250, 0);
    run_random_phase(73, 13, 19'd99999, 250, 0);
    run_random_phase(0, 0, MAX_WHOLE_RESET, 250, 60);

    drain();
    if (mismatches == 0 && pending == 0) begin
      $display("decimal_price_parser test passed");
    end else begin
      $display("decimal_price_parser test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
design/dpp_pkg.sv
design/dpp_if.sv
design/dpp_scan.sv
design/dpp_scale.sv
design/decimal_price_parser.sv
sim/dpp_price_checker.sv
sim/tb.sv
